/* design/edf_pkg.sv */
// ----------------------------------------------------------------------------
// edf_pkg: shared types and constants for the edf task scheduler
// Task count, time width, register indexes and the task setup layout.
// ----------------------------------------------------------------------------
`default_nettype none

package edf_pkg;

    localparam int NUM_TASKS  = 4;
    localparam int TIME_BITS  = 16;
    localparam int IDX_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    localparam int UNIT_W     = 16;
    localparam int OUT_TIME_W = 16;
    localparam int TASK_W     = 3;
    localparam int ACTIVE_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TASKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK1_SETUP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK4_SETUP  = 3'd4;

    // running task codes
    localparam logic [TASK_W-1:0] IDLE_TASK = 3'd0;
    localparam logic [TASK_W-1:0] NO_TASK   = 3'd7;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd1;

    typedef logic [UNIT_W-1:0]    t_units;
    typedef logic [TIME_BITS-1:0] t_time;

    // matches the setup register layout: period in 31:16, burst in 15:0
    typedef struct packed {
        t_units period;
        t_units burst;
    } t_task_cfg;

    localparam t_task_cfg TASK_CFG_RESET = '{period: 16'd1, burst: 16'd0};

    typedef struct packed {
        logic             have;
        logic [IDX_W-1:0] idx;
    } t_pick;

endpackage

`default_nettype wire

/* design/edf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// edf_cfg_regs: configuration registers
// Holds the active task count and the per-task burst and period setup.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_cfg_regs (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [edf_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [edf_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output      logic [edf_pkg::NUM_TASKS-1:0]          o_active,
    output      edf_pkg::t_task_cfg [edf_pkg::NUM_TASKS-1:0] o_task_cfg
);
    import edf_pkg::*;

    logic [ACTIVE_W-1:0] r_active;
    t_task_cfg [NUM_TASKS-1:0] r_task_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_task_cfg[i] <= TASK_CFG_RESET;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ACTIVE_TASKS) begin
                r_active <= i_cfg_data[ACTIVE_W-1:0];
            end
            for (int i = 0; i < NUM_TASKS; i++) begin
                if (i_cfg_index == CFG_TASK1_SETUP + CFG_IDX_W'(i)) begin
                    r_task_cfg[i] <= t_task_cfg'(i_cfg_data);
                end
            end
        end
    end

    // counts above the task count simply enable every task
    always_comb begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            o_active[i] = (ACTIVE_W'(i) < r_active);
        end
    end

    assign o_task_cfg = r_task_cfg;

endmodule

`default_nettype wire

/* design/edf_pick.sv */
// ----------------------------------------------------------------------------
// edf_pick: earliest deadline selection
// Picks the ready task with the smallest release countdown, lowest index on ties.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_pick (
    input  wire logic [edf_pkg::NUM_TASKS-1:0]            i_active,
    input  wire edf_pkg::t_units [edf_pkg::NUM_TASKS-1:0] i_work,
    input  wire edf_pkg::t_units [edf_pkg::NUM_TASKS-1:0] i_dist,
    output      edf_pkg::t_pick                           o_pick
);
    import edf_pkg::*;

    t_units best_dist;

    always_comb begin
        o_pick    = '0;
        best_dist = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            if (i_active[i] && (i_work[i] != '0) &&
                (!o_pick.have || (i_dist[i] < best_dist))) begin
                o_pick.have = 1'b1;
                o_pick.idx  = IDX_W'(i);
                best_dist   = i_dist[i];
            end
        end
    end

endmodule

`default_nettype wire

/* design/edf_periodic_task_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// edf_periodic_task_scheduler_unit: earliest deadline first scheduler
// One item is one time unit; releases, selection and countdowns per item.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// in        input      i_in_valid / o_in_stall  i_in_restart
// out       output     o_out_valid / i_out_stall tick_time, running_task,
//                                               switched, segment_start
// cfg       input      i_cfg_we                 i_cfg_index, i_cfg_data
//
// one item per cycle while the input is not stalled; an item's result is in
// the output register in the cycle after it is taken, set by release, compare
// and countdown logic per task. reset clears time, work, countdowns, previous
// task, run start and output valid; no clearing pass.
// the input is stalled only while a held result is stalled downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_periodic_task_scheduler_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output      logic                              o_in_stall,
    input  wire logic                              i_in_restart,
    output      logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    output      logic [edf_pkg::OUT_TIME_W-1:0]    o_out_tick_time,
    output      logic [edf_pkg::TASK_W-1:0]        o_out_running_task,
    output      logic                              o_out_switched,
    output      logic [edf_pkg::OUT_TIME_W-1:0]    o_out_segment_start,
    input  wire logic                              i_cfg_we,
    input  wire logic [edf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [edf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import edf_pkg::*;

    logic [NUM_TASKS-1:0]      active;
    t_task_cfg [NUM_TASKS-1:0] task_cfg;

    t_time                  r_time, n_time;
    t_units [NUM_TASKS-1:0] r_work, n_work;
    t_units [NUM_TASKS-1:0] r_rel, n_rel;
    logic [TASK_W-1:0]      r_prev, n_prev;
    t_time                  r_run_start, n_run_start;

    logic                   r_out_valid;
    logic [OUT_TIME_W-1:0]  r_out_time, n_out_time;
    logic [TASK_W-1:0]      r_out_task;
    logic                   r_out_sw;
    logic [OUT_TIME_W-1:0]  r_out_start, n_out_start;

    t_units [NUM_TASKS-1:0] rl_work, rl_rel;
    t_pick                  pick;
    logic [TASK_W-1:0]      cur_task, prev_e;
    t_time                  now_e;
    logic                   sw;
    logic                   in_accept;

    edf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_active    (active),
        .o_task_cfg  (task_cfg)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // restart clears run state first, then releases hit every active task whose countdown is zero
    always_comb begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            rl_work[i] = i_in_restart ? '0 : r_work[i];
            rl_rel[i]  = i_in_restart ? '0 : r_rel[i];
            if (active[i] && (rl_rel[i] == '0)) begin
                rl_work[i] = task_cfg[i].burst;
                rl_rel[i]  = (task_cfg[i].period == '0) ? UNIT_W'(1) : task_cfg[i].period;
            end
        end
    end

    edf_pick u_pick (
        .i_active (active),
        .i_work   (rl_work),
        .i_dist   (rl_rel),
        .o_pick   (pick)
    );

    always_comb begin
        now_e    = i_in_restart ? '0 : r_time;
        prev_e   = i_in_restart ? NO_TASK : r_prev;
        cur_task = pick.have ? (TASK_W'(pick.idx) + TASK_W'(1)) : IDLE_TASK;
        sw       = (cur_task != prev_e);

        n_prev      = cur_task;
        n_run_start = sw ? now_e : (i_in_restart ? '0 : r_run_start);
        n_time      = now_e + TIME_BITS'(1);

        for (int i = 0; i < NUM_TASKS; i++) begin
            n_work[i] = rl_work[i];
            if (pick.have && (pick.idx == IDX_W'(i))) begin
                n_work[i] = rl_work[i] - UNIT_W'(1);
            end
            n_rel[i] = active[i] ? (rl_rel[i] - UNIT_W'(1)) : rl_rel[i];
        end

        n_out_time  = OUT_TIME_W'(now_e);
        n_out_start = OUT_TIME_W'(n_run_start);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_work      <= '0;
            r_rel       <= '0;
            r_prev      <= NO_TASK;
            r_run_start <= '0;
        end else if (in_accept) begin
            r_time      <= n_time;
            r_work      <= n_work;
            r_rel       <= n_rel;
            r_prev      <= n_prev;
            r_run_start <= n_run_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_time  <= n_out_time;
            r_out_task  <= cur_task;
            r_out_sw    <= sw;
            r_out_start <= n_out_start;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_tick_time     = r_out_time;
    assign o_out_running_task  = r_out_task;
    assign o_out_switched      = r_out_sw;
    assign o_out_segment_start = r_out_start;

    // a switch starts a new segment at this very tick
    a_switch_starts_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_switched) |-> (o_out_segment_start == o_out_tick_time))
        else $error("segment start differs from tick time on a switch");

    a_task_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_running_task <= TASK_W'(NUM_TASKS)))
        else $error("running task beyond task count");

    a_restart_is_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_restart) |=>
            (o_out_valid && o_out_switched && (o_out_tick_time == '0)))
        else $error("restart item did not give a fresh time zero result");

    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted item produced no result");

endmodule

`default_nettype wire
